// ===== rtl/slx_pkg.sv =====
package slx_pkg;

	// Default width of the line counter
	localparam int LINE_BITS_DEF = 24;
	// Width of the line number carried with each result
	localparam int LINE_OUT_W    = 24;

	// Request queue between the front and back parts
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// Lexer modes
	typedef enum logic [2:0] {
		MODE_EMPTY = 3'd0,
		MODE_STR   = 3'd1,
		MODE_CHR   = 3'd2,
		MODE_NUM   = 3'd3,
		MODE_IDENT = 3'd4,
		MODE_RES   = 3'd5
	} lex_mode_t;

	// Token kinds
	localparam logic [3:0] KIND_STR     = 4'd0;
	localparam logic [3:0] KIND_CHR     = 4'd1;
	localparam logic [3:0] KIND_INT     = 4'd2;
	localparam logic [3:0] KIND_LCURLY  = 4'd3;
	localparam logic [3:0] KIND_RCURLY  = 4'd4;
	localparam logic [3:0] KIND_LPAREN  = 4'd5;
	localparam logic [3:0] KIND_RPAREN  = 4'd6;
	localparam logic [3:0] KIND_SEMI    = 4'd7;
	localparam logic [3:0] KIND_COLON   = 4'd8;
	localparam logic [3:0] KIND_OPER    = 4'd9;
	localparam logic [3:0] KIND_IDENT   = 4'd10;
	localparam logic [3:0] KIND_COMMA   = 4'd11;
	localparam logic [3:0] KIND_DOT     = 4'd12;
	localparam logic [3:0] KIND_LBRACK  = 4'd13;
	localparam logic [3:0] KIND_RBRACK  = 4'd14;

	// Character codes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LCURLY = 8'h7B;
	localparam logic [7:0] CH_RCURLY = 8'h7D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;

	// One request: one or two result characters of the same kind
	typedef struct packed {
		logic                  two;     // ch_a then ch_b, ch_b closes the token
		logic [7:0]            ch_a;
		logic [7:0]            ch_b;
		logic [3:0]            kind;
		logic                  end_a;   // end mark of ch_a when single
		logic                  error;
		logic [LINE_OUT_W-1:0] line;
	} req_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) || (c == CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_res(input logic [7:0] c);
		return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_PLUS) ||
			(c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
			(c == CH_LCURLY) || (c == CH_RCURLY) || (c == CH_SEMI) ||
			(c == CH_DOT) || (c == CH_LBRACK) || (c == CH_RBRACK) ||
			(c == CH_LT) || (c == CH_EQ) || (c == CH_GT) ||
			(c == CH_COLON) || (c == CH_COMMA);
	endfunction

	function automatic logic [3:0] res_kind(input logic [7:0] c);
		logic [3:0] k;
		case (c)
			CH_LCURLY: k = KIND_LCURLY;
			CH_RCURLY: k = KIND_RCURLY;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_SEMI:   k = KIND_SEMI;
			CH_COLON:  k = KIND_COLON;
			CH_COMMA:  k = KIND_COMMA;
			CH_DOT:    k = KIND_DOT;
			CH_LBRACK: k = KIND_LBRACK;
			CH_RBRACK: k = KIND_RBRACK;
			default:   k = KIND_OPER;
		endcase
		return k;
	endfunction

	// Second character that turns a reserved character into a two-character operator
	function automatic logic joins(input logic [7:0] first, input logic [7:0] nxt);
		return ((first == CH_MINUS) && (nxt == CH_GT)) ||
			((nxt == CH_EQ) && ((first == CH_PLUS) || (first == CH_MINUS) ||
			(first == CH_SLASH) || (first == CH_STAR) || (first == CH_EQ) ||
			(first == CH_LT) || (first == CH_GT)));
	endfunction

	function automatic logic esc_known(input logic [7:0] c);
		return (c == CH_LOW_T) || (c == CH_LOW_N) || (c == CH_DQUOTE) || (c == CH_ZERO);
	endfunction

	function automatic logic [7:0] esc_xlate(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			CH_LOW_T: r = CH_TAB;
			CH_LOW_N: r = CH_NL;
			CH_ZERO:  r = CH_NUL;
			default:  r = c;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/slx_front.sv =====
module slx_front
	import slx_pkg::*;
#(
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic       op,
	input  logic [7:0] ch,
	output logic       push,
	output req_t       push_req
);

	localparam int LINE_EXT_W = (LINE_BITS > LINE_OUT_W) ? LINE_BITS : LINE_OUT_W;

	lex_mode_t            mode_q, mode_d;
	logic                 esc_q, esc_d;
	logic [7:0]           held_char_q, held_char_d;
	logic [3:0]           held_kind_q, held_kind_d;
	logic                 held_valid_q, held_valid_d;
	logic [LINE_BITS-1:0] line_q, line_d;
	logic [LINE_EXT_W-1:0] line_ext;

	lex_mode_t  st_mode;
	logic       st_hold;
	logic [3:0] st_kind;
	logic [7:0] lit_close;
	logic       c_space, c_digit, c_res, c_join, c_esc;

	assign c_space   = is_space(ch);
	assign c_digit   = is_digit(ch);
	assign c_res     = is_res(ch);
	assign c_join    = joins(held_char_q, ch);
	assign c_esc     = esc_known(ch);
	assign lit_close = (mode_q == MODE_STR) ? CH_DQUOTE : CH_SQUOTE;

	// Classify a byte that opens a new token
	always_comb begin
		st_mode = MODE_EMPTY;
		st_hold = 1'b1;
		st_kind = KIND_IDENT;
		priority if (c_space) begin
			st_hold = 1'b0;
		end else if (ch == CH_DQUOTE) begin
			st_mode = MODE_STR;
			st_kind = KIND_STR;
		end else if (ch == CH_SQUOTE) begin
			st_mode = MODE_CHR;
			st_kind = KIND_CHR;
		end else if (c_digit) begin
			st_mode = MODE_NUM;
			st_kind = KIND_INT;
		end else if (c_res) begin
			st_mode = MODE_RES;
			st_kind = res_kind(ch);
		end else begin
			st_mode = MODE_IDENT;
		end
	end

	// Next state of the lexer
	always_comb begin
		mode_d       = mode_q;
		esc_d        = esc_q;
		held_char_d  = held_char_q;
		held_kind_d  = held_kind_q;
		held_valid_d = held_valid_q;
		line_d       = line_q;
		if (accept) begin
			if (op) begin
				mode_d       = MODE_EMPTY;
				esc_d        = 1'b0;
				held_valid_d = 1'b0;
			end else begin
				if ((ch == CH_NL) && (line_q != {LINE_BITS{1'b1}})) begin
					line_d = line_q + 1'b1;
				end
				unique case (mode_q)
					MODE_STR, MODE_CHR: begin
						if (esc_q) begin
							esc_d = 1'b0;
							if (c_esc) begin
								held_char_d = esc_xlate(ch);
							end
						end else if (ch == CH_BSLASH) begin
							esc_d = 1'b1;
						end else if (ch == lit_close) begin
							mode_d       = MODE_EMPTY;
							held_valid_d = 1'b0;
						end else begin
							held_char_d = ch;
						end
					end
					MODE_NUM, MODE_IDENT, MODE_RES: begin
						if ((mode_q == MODE_NUM) && c_digit) begin
							held_char_d = ch;
						end else if ((mode_q == MODE_IDENT) && !(c_space || c_res)) begin
							held_char_d = ch;
						end else if ((mode_q == MODE_RES) && c_join) begin
							mode_d       = MODE_EMPTY;
							held_valid_d = 1'b0;
						end else begin
							// token closed: handle the byte as a fresh start
							mode_d       = st_mode;
							esc_d        = 1'b0;
							held_valid_d = st_hold;
							held_char_d  = ch;
							held_kind_d  = st_kind;
						end
					end
					default: begin
						mode_d       = st_mode;
						esc_d        = 1'b0;
						held_valid_d = st_hold;
						held_char_d  = ch;
						held_kind_d  = st_kind;
					end
				endcase
			end
		end
	end

	assign line_ext = LINE_EXT_W'(line_d);

	// Request to the back part
	always_comb begin
		push           = 1'b0;
		push_req.two   = 1'b0;
		push_req.ch_a  = held_char_q;
		push_req.ch_b  = ch;
		push_req.kind  = held_kind_q;
		push_req.end_a = 1'b1;
		push_req.error = 1'b0;
		push_req.line  = line_ext[LINE_OUT_W-1:0];
		if (accept) begin
			if (op) begin
				push           = (mode_q != MODE_EMPTY);
				push_req.error = (mode_q != MODE_RES);
			end else begin
				unique case (mode_q)
					MODE_STR, MODE_CHR: begin
						if (esc_q) begin
							push           = c_esc;
							push_req.end_a = 1'b0;
						end else if (ch != CH_BSLASH) begin
							push           = 1'b1;
							push_req.two   = (ch == lit_close);
							push_req.end_a = 1'b0;
						end
					end
					MODE_NUM: begin
						push           = 1'b1;
						push_req.end_a = !c_digit;
					end
					MODE_IDENT: begin
						push           = 1'b1;
						push_req.end_a = c_space || c_res;
					end
					MODE_RES: begin
						push           = 1'b1;
						push_req.two   = c_join;
						push_req.end_a = !c_join;
					end
					default: begin
						push = 1'b0;
					end
				endcase
			end
		end
	end

	// Hold lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_EMPTY;
			esc_q        <= 1'b0;
			held_char_q  <= '0;
			held_kind_q  <= '0;
			held_valid_q <= 1'b0;
			line_q       <= LINE_BITS'(1);
		end else begin
			mode_q       <= mode_d;
			esc_q        <= esc_d;
			held_char_q  <= held_char_d;
			held_kind_q  <= held_kind_d;
			held_valid_q <= held_valid_d;
			line_q       <= line_d;
		end
	end

	a_held_in_token: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_EMPTY) |-> held_valid_q)
		else $error("open token without a held character");

	a_held_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_EMPTY) |-> (!held_valid_q && !esc_q))
		else $error("held character or escape left in empty mode");

	a_esc_literal: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q |-> ((mode_q == MODE_STR) || (mode_q == MODE_CHR)))
		else $error("escape pending outside a literal");

endmodule

// ===== rtl/slx_fifo.sv =====
module slx_fifo
	import slx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  req_t push_req,
	output logic full,
	input  logic pop,
	output req_t head,
	output logic not_empty
);

	req_t             mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (count_q == CNT_W'(FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Store the pushed request
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= advance(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= advance(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into a full request queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("pop from an empty request queue");

endmodule

// ===== rtl/slx_back.sv =====
module slx_back
	import slx_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  req_t                  q_head,
	output logic                  q_pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_char,
	output logic [3:0]            out_kind,
	output logic                  out_end,
	output logic [LINE_OUT_W-1:0] out_line,
	output logic                  out_error
);

	logic                  valid_q;
	logic                  sel_q;
	logic [7:0]            char_q;
	logic [3:0]            kind_q;
	logic                  end_q;
	logic [LINE_OUT_W-1:0] line_q;
	logic                  error_q;
	logic                  load;
	logic                  first_of_two;

	assign load         = q_valid && (!valid_q || out_ready);
	assign first_of_two = q_head.two && !sel_q;
	assign q_pop        = load && !first_of_two;

	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_kind  = kind_q;
	assign out_end   = end_q;
	assign out_line  = line_q;
	assign out_error = error_q;

	// Load the output register from the head request
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= q_head.kind;
			line_q <= q_head.line;
			if (first_of_two) begin
				char_q  <= q_head.ch_a;
				end_q   <= 1'b0;
				error_q <= 1'b0;
			end else if (sel_q) begin
				char_q  <= q_head.ch_b;
				end_q   <= 1'b1;
				error_q <= 1'b0;
			end else begin
				char_q  <= q_head.ch_a;
				end_q   <= q_head.end_a;
				error_q <= q_head.error;
			end
		end
	end

	// Track output valid and the half of a two-character request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				sel_q   <= first_of_two;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	a_second_half: assert property (@(posedge clk) disable iff (!arst_n)
		sel_q |-> (q_valid && q_head.two))
		else $error("second character pending without a two-character request");

endmodule

// ===== rtl/source_lexer.sv =====
// Channel   Dir  Bus fields                                   Handshake
// s_axis    in   tdata[7:0] ch; tuser[0] op (1 = end of input) tvalid/tready
// m_axis    out  tdata[7:0] text_char, tdata[31:8] line_number;
//                tuser[3:0] kind, tuser[4] error; tlast token_end tvalid/tready
//
// A source byte is accepted whenever the request queue has room;
// the front part decides all results of the byte in the cycle that accepts it.
// Each accepted byte yields zero, one or two result characters; the back part
// sends one result per cycle while m_axis_tready is high, so output bandwidth sets the sustained rate.
// A result passes through the request queue and then the output register before it is valid on m_axis.
// Reset clears the lexer state, the queue and the output register; line count
// restarts at 1. A stalled m_axis side backs up through the queue to s_axis.
module source_lexer
	import slx_pkg::*;
#(
	parameter int LINE_BITS = LINE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	input  logic [0:0]  s_axis_tuser,   // [0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [7:0] text_char, [31:8] line_number
	output logic [4:0]  m_axis_tuser,   // [3:0] kind, [4] error
	output logic        m_axis_tlast
);

	logic                  accept;
	logic                  push;
	req_t                  push_req;
	logic                  q_full;
	logic                  q_pop;
	req_t                  q_head;
	logic                  q_valid;
	logic [7:0]            out_char;
	logic [3:0]            out_kind;
	logic [LINE_OUT_W-1:0] out_line;
	logic                  out_error;

	assign s_axis_tready = !q_full;
	assign accept        = s_axis_tvalid && !q_full;

	slx_front #(
		.LINE_BITS(LINE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.op       (s_axis_tuser[0]),
		.ch       (s_axis_tdata),
		.push     (push),
		.push_req (push_req)
	);

	slx_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_req  (push_req),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_valid)
	);

	slx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_kind  (out_kind),
		.out_end   (m_axis_tlast),
		.out_line  (out_line),
		.out_error (out_error)
	);

	// Pack the result fields
	assign m_axis_tdata = {out_line, out_char};
	assign m_axis_tuser = {out_error, out_kind};

endmodule

// ===== test/source_lexer_tb.sv =====
`timescale 1ns / 1ps

module source_lexer_tb;
	import slx_pkg::*;

	// One character of token text as it should leave the lexer
	typedef struct packed {
		logic [7:0]            text_char;
		logic [3:0]            kind;
		logic                  token_end;
		logic [LINE_OUT_W-1:0] line_number;
		logic                  error;
	} tok_char_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] ch
	logic [0:0]  s_axis_tuser;   // [0] op
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;   // [7:0] text_char, [31:8] line_number
	logic [4:0]  m_axis_tuser;   // [3:0] kind, [4] error
	logic        m_axis_tlast;

	// Predicted lexer state
	lex_mode_t             lx_mode = MODE_EMPTY;
	logic                  esc_pend = 1'b0;
	logic [7:0]            held_ch = 8'h00;
	logic [3:0]            held_kd = 4'h0;
	logic                  held_ok = 1'b0;
	logic [LINE_OUT_W-1:0] line_cnt = LINE_OUT_W'(1);

	tok_char_t pending_chars[$];
	int        mismatches = 0;
	int        lexed_bytes = 0;
	bit        idle_on = 1'b1;

	source_lexer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ---------------------------------------------------------------
	// Character classes of the source language
	// ---------------------------------------------------------------
	function automatic logic lx_blank(input logic [7:0] c);
		case (c)
			CH_SPACE, CH_NL, CH_TAB, CH_CR: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic lx_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic lx_punct(input logic [7:0] c);
		case (c)
			CH_LPAREN, CH_RPAREN, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
			CH_LCURLY, CH_RCURLY, CH_SEMI, CH_DOT, CH_LBRACK, CH_RBRACK,
			CH_LT, CH_EQ, CH_GT, CH_COLON, CH_COMMA: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function automatic logic [3:0] punct_kind(input logic [7:0] c);
		case (c)
			CH_LCURLY: return KIND_LCURLY;
			CH_RCURLY: return KIND_RCURLY;
			CH_LPAREN: return KIND_LPAREN;
			CH_RPAREN: return KIND_RPAREN;
			CH_SEMI:   return KIND_SEMI;
			CH_COLON:  return KIND_COLON;
			CH_COMMA:  return KIND_COMMA;
			CH_DOT:    return KIND_DOT;
			CH_LBRACK: return KIND_LBRACK;
			CH_RBRACK: return KIND_RBRACK;
			default:   return KIND_OPER;
		endcase
	endfunction

	// Two-character operators: "->" and a reserved operator followed by '='
	function automatic logic pairs_with(input logic [7:0] first, input logic [7:0] nxt);
		if (first == CH_MINUS && nxt == CH_GT)
			return 1'b1;
		if (nxt != CH_EQ)
			return 1'b0;
		case (first)
			CH_PLUS, CH_MINUS, CH_SLASH, CH_STAR, CH_EQ, CH_LT, CH_GT: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Token text prediction
	// ---------------------------------------------------------------
	function automatic void emit_char(input logic [7:0] c, input logic [3:0] k,
			input logic last, input logic err);
		tok_char_t e;
		e.text_char   = c;
		e.kind        = k;
		e.token_end   = last;
		e.line_number = line_cnt;
		e.error       = err;
		pending_chars.push_back(e);
	endfunction

	// Hold the new character; release the previous one as non-final
	function automatic void hold_char(input logic [7:0] c, input logic [3:0] k);
		if (held_ok)
			emit_char(held_ch, held_kd, 1'b0, 1'b0);
		held_ch = c;
		held_kd = k;
		held_ok = 1'b1;
	endfunction

	// Close the token: the held character goes out with the end mark
	function automatic void close_token(input logic err);
		if (held_ok)
			emit_char(held_ch, held_kd, 1'b1, err);
		held_ok  = 1'b0;
		lx_mode  = MODE_EMPTY;
		esc_pend = 1'b0;
	endfunction

	function automatic void literal_step(input logic [7:0] c, input logic [7:0] closer,
			input logic [3:0] k);
		if (esc_pend) begin
			esc_pend = 1'b0;
			// translate known escapes, drop any other
			case (c)
				CH_LOW_T:  hold_char(CH_TAB, k);
				CH_LOW_N:  hold_char(CH_NL, k);
				CH_DQUOTE: hold_char(CH_DQUOTE, k);
				CH_ZERO:   hold_char(CH_NUL, k);
				default: ;
			endcase
		end else if (c == CH_BSLASH) begin
			esc_pend = 1'b1;
		end else begin
			hold_char(c, k);
			if (c == closer)
				close_token(1'b0);
		end
	endfunction

	function automatic void tokenize_byte(input logic op, input logic [7:0] c);
		logic redo;
		int   pass;
		// end of input: flush a pending reserved token, flag any other open token
		if (op) begin
			if (lx_mode == MODE_RES)
				close_token(1'b0);
			else if (lx_mode != MODE_EMPTY)
				close_token(1'b1);
			lx_mode  = MODE_EMPTY;
			esc_pend = 1'b0;
			return;
		end
		if (c == CH_NL && line_cnt != '1)
			line_cnt++;
		// a byte that ends a number, identifier or reserved token is lexed again
		redo = 1'b1;
		for (pass = 0; pass < 2 && redo; pass++) begin
			redo = 1'b0;
			case (lx_mode)
				MODE_STR: literal_step(c, CH_DQUOTE, KIND_STR);
				MODE_CHR: literal_step(c, CH_SQUOTE, KIND_CHR);
				MODE_NUM: begin
					if (lx_digit(c)) begin
						hold_char(c, KIND_INT);
					end else begin
						close_token(1'b0);
						redo = 1'b1;
					end
				end
				MODE_IDENT: begin
					if (lx_blank(c) || lx_punct(c)) begin
						close_token(1'b0);
						redo = 1'b1;
					end else begin
						hold_char(c, KIND_IDENT);
					end
				end
				MODE_RES: begin
					if (held_ok && pairs_with(held_ch, c)) begin
						hold_char(c, held_kd);
						close_token(1'b0);
					end else begin
						close_token(1'b0);
						redo = 1'b1;
					end
				end
				default: begin
					lx_mode  = MODE_EMPTY;
					esc_pend = 1'b0;
					if (lx_blank(c)) begin
						// skip
					end else if (c == CH_DQUOTE) begin
						hold_char(c, KIND_STR);
						lx_mode = MODE_STR;
					end else if (c == CH_SQUOTE) begin
						hold_char(c, KIND_CHR);
						lx_mode = MODE_CHR;
					end else if (lx_digit(c)) begin
						hold_char(c, KIND_INT);
						lx_mode = MODE_NUM;
					end else if (lx_punct(c)) begin
						hold_char(c, punct_kind(c));
						lx_mode = MODE_RES;
					end else begin
						hold_char(c, KIND_IDENT);
						lx_mode = MODE_IDENT;
					end
				end
			endcase
		end
	endfunction

	// ---------------------------------------------------------------
	// Request driver: called and left at a falling edge
	// ---------------------------------------------------------------
	task automatic send_item(input logic op, input logic [7:0] c);
		while (idle_on && $urandom_range(0, 99) < 23) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid   <= 1'b1;
		s_axis_tdata    <= c;
		s_axis_tuser[0] <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		// blanks between tokens are skipped by the lexer and not counted
		if (op || lx_mode != MODE_EMPTY || !lx_blank(c))
			lexed_bytes++;
		tokenize_byte(op, c);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_item(1'b0, s[i]);
	endtask

	// Random literal body character, escaped at times
	task automatic send_literal_char(input logic [7:0] closer);
		string      escs;
		logic [7:0] c;
		escs = "tn\"0";
		if ($urandom_range(0, 3) == 0) begin
			send_item(1'b0, CH_BSLASH);
			if ($urandom_range(0, 4) == 0)
				c = 8'($urandom_range(32, 126));
			else
				c = escs[$urandom_range(0, 3)];
			send_item(1'b0, c);
		end else begin
			c = 8'($urandom_range(32, 126));
			if (c == closer || c == CH_BSLASH)
				c = 8'h61;
			if ($urandom_range(0, 19) == 0)
				c = CH_NL;
			send_item(1'b0, c);
		end
	endtask

	function automatic logic [7:0] pick_letter();
		case ($urandom_range(0, 2))
			0: return 8'($urandom_range(8'h61, 8'h7A));
			1: return 8'($urandom_range(8'h41, 8'h5A));
			default: return 8'h5F;
		endcase
	endfunction

	// Mostly well-formed tokens with random content, some noise and cut-off input
	task automatic send_token();
		string      puncts;
		string      blanks;
		int         sel;
		int         i;
		logic [7:0] c;
		puncts = "(){}[];:.,+-*/<=>";
		blanks = " \n\t\r";
		sel = $urandom_range(0, 99);
		if (sel < 15) begin
			send_item(1'b0, CH_DQUOTE);
			repeat ($urandom_range(0, 5))
				send_literal_char(CH_DQUOTE);
			send_item(1'b0, CH_DQUOTE);
		end else if (sel < 23) begin
			send_item(1'b0, CH_SQUOTE);
			send_literal_char(CH_SQUOTE);
			send_item(1'b0, CH_SQUOTE);
		end else if (sel < 38) begin
			repeat ($urandom_range(1, 4))
				send_item(1'b0, 8'($urandom_range(CH_ZERO, CH_NINE)));
		end else if (sel < 56) begin
			send_item(1'b0, pick_letter());
			for (i = $urandom_range(0, 5); i > 0; i--) begin
				c = ($urandom_range(0, 3) == 0) ?
					8'($urandom_range(CH_ZERO, CH_NINE)) : pick_letter();
				send_item(1'b0, c);
			end
		end else if (sel < 76) begin
			send_item(1'b0, puncts[$urandom_range(0, 16)]);
			if ($urandom_range(0, 9) < 4)
				send_item(1'b0, $urandom_range(0, 1) ? CH_EQ : CH_GT);
		end else if (sel < 90) begin
			repeat ($urandom_range(1, 2))
				send_item(1'b0, blanks[$urandom_range(0, 3)]);
		end else if (sel < 96) begin
			send_item(1'b0, 8'($urandom_range(0, 255)));
		end else begin
			send_item(1'b1, 8'($urandom_range(0, 255)));
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// String with every escape and a dropped one
	task automatic test_string_escapes();
		send_text("\"\\t\\n\\\"\\0\\x\"");
	endtask

	// Newline ends a number and is counted once
	task automatic test_number_newline();
		send_text("7\n");
	endtask

	// "->" joins, the trailing '=' is flushed by end of input
	task automatic test_operator_joins();
		send_text("->=");
		send_item(1'b1, 8'hFF);
	endtask

	// Open identifier and char literal at end of input, end of input when empty
	task automatic test_end_of_input();
		send_item(1'b0, 8'hFF);
		send_item(1'b0, 8'h00);
		send_item(1'b1, 8'h00);
		send_item(1'b1, 8'h00);
		send_item(1'b0, CH_SQUOTE);
		send_item(1'b1, 8'h00);
	endtask

	task automatic test_random_tokens(input int target);
		int start;
		start = lexed_bytes;
		while (lexed_bytes - start < target)
			send_token();
	endtask

	// Full rate on both sides
	task automatic test_back_to_back(input int target);
		idle_on = 1'b0;
		test_random_tokens(target);
		idle_on = 1'b1;
	endtask

	// ---------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk) begin
		m_axis_tready <= !(idle_on && $urandom_range(0, 99) < 23);
	end

	always @(posedge clk) begin : result_check
		tok_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_chars.size() == 0) begin
				$error("unexpected result: text_char %0h", m_axis_tdata[7:0]);
				mismatches++;
			end else begin
				want = pending_chars.pop_front();
				check_field("text_char", 32'(want.text_char), 32'(m_axis_tdata[7:0]));
				check_field("kind", 32'(want.kind), 32'(m_axis_tuser[3:0]));
				check_field("token_end", 32'(want.token_end), 32'(m_axis_tlast));
				check_field("line_number", 32'(want.line_number),
					32'(m_axis_tdata[31:8]));
				check_field("error", 32'(want.error), 32'(m_axis_tuser[4]));
			end
		end
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'h00;
		s_axis_tuser  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_string_escapes();
		test_number_newline();
		test_operator_joins();
		test_end_of_input();
		test_random_tokens(100);
		test_back_to_back(40);

		s_axis_tvalid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("source_lexer_tb OK");
		else
			$display("source_lexer_tb NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("source_lexer_tb NOT OK");
		$finish;
	end

endmodule
